[design/primitive_assembler_core_assert.svh]
// ----------------------------------------------------------------------------
// primitive_assembler_core_assert.svh
// Assertion macros used by the primitive assembler checker.
// ----------------------------------------------------------------------------
`ifndef PRIMITIVE_ASSEMBLER_CORE_ASSERT_SVH
`define PRIMITIVE_ASSEMBLER_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define PA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pa assertion failed");

// next-cycle implication, off during reset
`define PA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pa assertion failed");

// next-cycle implication, always on
`define PA_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("pa assertion failed");

`endif

[design/pa_pkg.sv]
// ----------------------------------------------------------------------------
// pa_pkg
// Types, type codes and window tables of the primitive assembler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pa_pkg;

   localparam int INDEX_W   = 32;
   localparam int TYPE_W    = 4;
   localparam int COUNT_W   = 3;
   localparam int ORD_OUT_W = 16;

   localparam logic [TYPE_W-1:0] PT_POINTS    = 4'd0;
   localparam logic [TYPE_W-1:0] PT_LINES     = 4'd1;
   localparam logic [TYPE_W-1:0] PT_LINE_LOOP = 4'd2;
   localparam logic [TYPE_W-1:0] PT_LINE_STRP = 4'd3;
   localparam logic [TYPE_W-1:0] PT_TRIS      = 4'd4;
   localparam logic [TYPE_W-1:0] PT_TRI_STRP  = 4'd5;
   localparam logic [TYPE_W-1:0] PT_TRI_FAN   = 4'd6;
   localparam logic [TYPE_W-1:0] PT_QUADS     = 4'd7;
   localparam logic [TYPE_W-1:0] PT_QUAD_STRP = 4'd8;
   localparam logic [TYPE_W-1:0] PT_NONE      = 4'd15;

   typedef struct packed {
      logic [TYPE_W-1:0]  prim_type;
      logic               new_run;
      logic [COUNT_W-1:0] win;
      logic [COUNT_W-1:0] step;
   } pa_ctl_type;

   function automatic logic [COUNT_W-1:0] win_size(input logic [TYPE_W-1:0] t);
      logic [COUNT_W-1:0] w;
      case (t) inside
         PT_POINTS:                           w = 3'd1;
         PT_LINES, PT_LINE_LOOP, PT_LINE_STRP: w = 3'd2;
         PT_TRIS, PT_TRI_STRP, PT_TRI_FAN:    w = 3'd3;
         PT_QUADS, PT_QUAD_STRP:              w = 3'd4;
         default:                             w = 3'd0;
      endcase
      return w;
   endfunction

   function automatic logic [COUNT_W-1:0] win_step(input logic [TYPE_W-1:0] t);
      logic [COUNT_W-1:0] s;
      case (t) inside
         PT_POINTS, PT_LINE_LOOP, PT_LINE_STRP, PT_TRI_STRP, PT_TRI_FAN: s = 3'd1;
         PT_LINES, PT_QUAD_STRP:                                         s = 3'd2;
         PT_TRIS:                                                        s = 3'd3;
         PT_QUADS:                                                       s = 3'd4;
         default:                                                        s = 3'd0;
      endcase
      return s;
   endfunction

endpackage

[design/pa_if.sv]
// ----------------------------------------------------------------------------
// pa_if
// Valid/ready channel interfaces for vertex requests and primitive responses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pa_req_if import pa_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] vertex_index;
   logic [TYPE_W-1:0]  prim_type;
   logic               run_start;

   modport source (output valid, vertex_index, prim_type, run_start, input ready);
   modport sink   (input valid, vertex_index, prim_type, run_start, output ready);
endinterface

interface pa_rsp_if import pa_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [TYPE_W-1:0]    out_type;
   logic [INDEX_W-1:0]   corner_a;
   logic [INDEX_W-1:0]   corner_b;
   logic [INDEX_W-1:0]   corner_c;
   logic [INDEX_W-1:0]   corner_d;
   logic [COUNT_W-1:0]   corner_count;
   logic [ORD_OUT_W-1:0] prim_ordinal;

   modport source (output valid, out_type, corner_a, corner_b, corner_c, corner_d,
                   corner_count, prim_ordinal, input ready);
   modport sink   (input valid, out_type, corner_a, corner_b, corner_c, corner_d,
                   corner_count, prim_ordinal, output ready);
endinterface

[design/pa_queue.sv]
// ----------------------------------------------------------------------------
// pa_queue
// Two-entry queue between the classifier and the assembler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pa_queue import pa_pkg::*; #(
   parameter int WIDTH = 48
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[design/pa_front.sv]
// ----------------------------------------------------------------------------
// pa_front
// Accepts vertex transfers, tracks run boundaries and looks up the window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pa_front import pa_pkg::*; #(
   parameter int INDEX_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   pa_req_if.sink                req,
   input  logic                  q_full,
   output logic                  push,
   output logic [INDEX_BITS-1:0] push_index,
   output pa_ctl_type            push_ctl
);

   logic [TYPE_W-1:0] run_type_ff, run_type_in;

   assign req.ready  = !q_full;
   assign push       = req.valid && !q_full;
   assign push_index = INDEX_BITS'(req.vertex_index);

   always_comb begin
      push_ctl.prim_type = req.prim_type;
      push_ctl.new_run   = req.run_start || (req.prim_type != run_type_ff);
      push_ctl.win       = win_size(req.prim_type);
      push_ctl.step      = win_step(req.prim_type);
      run_type_in        = push ? req.prim_type : run_type_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_type_ff <= PT_NONE;
      end else begin
         run_type_ff <= run_type_in;
      end
   end

endmodule

[design/pa_back.sv]
// ----------------------------------------------------------------------------
// pa_back
// Slides the vertex window, builds primitives and holds the response register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pa_back import pa_pkg::*; #(
   parameter int INDEX_BITS   = 32,
   parameter int ORDINAL_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  logic [INDEX_BITS-1:0] q_index,
   input  pa_ctl_type            q_ctl,
   output logic                  pop,
   pa_rsp_if.source              rsp
);

   logic [INDEX_BITS-1:0]   r0_ff, r1_ff, r2_ff, pivot_ff;
   logic [INDEX_BITS-1:0]   pivot_in;
   logic [COUNT_W-1:0]      fill_ff, fill_in;
   logic [ORDINAL_BITS-1:0] ord_ff, ord_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [TYPE_W-1:0]       type_ff;
   logic [INDEX_BITS-1:0]   ca_ff, cb_ff, cc_ff, cd_ff;
   logic [INDEX_BITS-1:0]   ca_in, cb_in, cc_in, cd_in;
   logic [COUNT_W-1:0]      count_ff;
   logic [ORDINAL_BITS-1:0] ordo_ff;

   logic [COUNT_W-1:0]      fill_eff;
   logic [ORDINAL_BITS-1:0] ord_eff;
   logic                    known;
   logic                    emit;

   assign pop = q_valid && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      fill_eff = q_ctl.new_run ? '0 : fill_ff;
      ord_eff  = q_ctl.new_run ? '0 : ord_ff;
      known    = (q_ctl.win != '0);
      emit     = known && ((fill_eff + 3'd1) >= q_ctl.win);

      ca_in = '0;
      cb_in = '0;
      cc_in = '0;
      cd_in = '0;
      case (q_ctl.win)
         3'd1: begin
            ca_in = q_index;
         end
         3'd2: begin
            ca_in = r2_ff;
            cb_in = q_index;
         end
         3'd3: begin
            ca_in = r1_ff;
            cb_in = r2_ff;
            cc_in = q_index;
         end
         3'd4: begin
            ca_in = r0_ff;
            cb_in = r1_ff;
            cc_in = r2_ff;
            cd_in = q_index;
         end
         default: begin
            ca_in = '0;
         end
      endcase
      if (q_ctl.prim_type == PT_TRI_FAN) begin
         ca_in = pivot_ff;
      end

      pivot_in = (known && fill_eff == '0) ? q_index : pivot_ff;

      if (!known) begin
         fill_in = fill_eff;
         ord_in  = ord_eff;
      end else if (emit) begin
         fill_in = q_ctl.win - q_ctl.step;
         ord_in  = (ord_eff != '1) ? ord_eff + 1'b1 : ord_eff;
      end else begin
         fill_in = fill_eff + 3'd1;
         ord_in  = ord_eff;
      end

      rsp_valid_in = (pop && emit) || (rsp_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         ord_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         r0_ff        <= '0;
         r1_ff        <= '0;
         r2_ff        <= '0;
         pivot_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            fill_ff  <= fill_in;
            ord_ff   <= ord_in;
            pivot_ff <= pivot_in;
            r0_ff    <= r1_ff;
            r1_ff    <= r2_ff;
            r2_ff    <= q_index;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit) begin
         type_ff  <= q_ctl.prim_type;
         ca_ff    <= ca_in;
         cb_ff    <= cb_in;
         cc_ff    <= cc_in;
         cd_ff    <= cd_in;
         count_ff <= q_ctl.win;
         ordo_ff  <= ord_eff;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.out_type     = type_ff;
   assign rsp.corner_a     = INDEX_W'(ca_ff);
   assign rsp.corner_b     = INDEX_W'(cb_ff);
   assign rsp.corner_c     = INDEX_W'(cc_ff);
   assign rsp.corner_d     = INDEX_W'(cd_ff);
   assign rsp.corner_count = count_ff;
   assign rsp.prim_ordinal = ORD_OUT_W'(ordo_ff);

endmodule

[design/primitive_assembler_core.sv]
// ----------------------------------------------------------------------------
// primitive_assembler_core
// Assembles points, lines, triangles and quads from a tagged index stream.
//
//   channel   dir   handshake        payload
//   req       in    valid / ready    vertex_index, prim_type, run_start
//   rsp       out   valid / ready    out_type, corner_a..d, corner_count,
//                                    prim_ordinal
//
// One index per clock while rsp is not stalled; the completing index is queued
// and its primitive then registered. The two-entry queue and the response
// register let req keep flowing while rsp is stalled, until both fill.
// Synchronous reset clears run tracking, window fill and ordinal counters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module primitive_assembler_core import pa_pkg::*; #(
   parameter int INDEX_BITS   = 32,
   parameter int ORDINAL_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   pa_req_if.sink    req,
   pa_rsp_if.source  rsp
);

   localparam int ENTRY_W = INDEX_BITS + $bits(pa_ctl_type);

   logic                  push;
   logic [INDEX_BITS-1:0] push_index;
   pa_ctl_type            push_ctl;
   logic                  q_full;
   logic                  q_valid;
   logic                  pop;
   logic [ENTRY_W-1:0]    q_data;
   logic [INDEX_BITS-1:0] q_index;
   pa_ctl_type            q_ctl;

   pa_front #(.INDEX_BITS(INDEX_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .q_full     (q_full),
      .push       (push),
      .push_index (push_index),
      .push_ctl   (push_ctl)
   );

   pa_queue #(.WIDTH(ENTRY_W)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_index, push_ctl}),
      .full      (q_full),
      .pop       (pop),
      .not_empty (q_valid),
      .pop_data  (q_data)
   );

   assign q_index = q_data[ENTRY_W-1 -: INDEX_BITS];
   assign q_ctl   = q_data[$bits(pa_ctl_type)-1:0];

   pa_back #(.INDEX_BITS(INDEX_BITS), .ORDINAL_BITS(ORDINAL_BITS)) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_index (q_index),
      .q_ctl   (q_ctl),
      .pop     (pop),
      .rsp     (rsp)
   );

endmodule

[design/pa_checker.sv]
// ----------------------------------------------------------------------------
// pa_checker
// Port-level checks on the primitive assembler response stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "primitive_assembler_core_assert.svh"

module pa_checker import pa_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [TYPE_W-1:0]    out_type,
   input logic [INDEX_W-1:0]   corner_d,
   input logic [COUNT_W-1:0]   corner_count
);

   `PA_ASSERT_ALWAYS_NEXT(a_idle_after_reset, clock, reset, !rsp_valid)
   `PA_ASSERT_NEXT(a_hold_stalled, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `PA_ASSERT_IMPLY(a_count_range, clock, reset, rsp_valid, corner_count != 3'd0 && corner_count <= 3'd4)
   `PA_ASSERT_IMPLY(a_known_type, clock, reset, rsp_valid, out_type <= PT_QUAD_STRP)
   `PA_ASSERT_IMPLY(a_unused_corner, clock, reset, rsp_valid && corner_count != 3'd4, corner_d == '0)

endmodule

bind primitive_assembler_core pa_checker u_pa_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .out_type     (rsp.out_type),
   .corner_d     (rsp.corner_d),
   .corner_count (rsp.corner_count)
);
